// ===== src/cht_pkg.sv =====
// Shared types and constants of the chained hash table.
`default_nettype none

package cht_pkg;

  localparam int KEY_W = 31;
  localparam int POS_W = 4;
  // The bucket remainder is built in three steps: multiply, subtract, correct.
  localparam int MOD_STAGES = 3;
  localparam int CNT_W = $clog2(MOD_STAGES);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_FILL_RD,
    S_FILL_CHK,
    S_KEY_RD,
    S_KEY_CMP,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_wr;
    logic    load_in;
    logic    mod_step;
    logic    fill_rd;
    logic    ins_wr;
    logic    idx_clr;
    logic    idx_inc;
    logic    key_rd;
    logic    res_load;
    status_t res_status;
    logic    out_load;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic is_search;
    logic fill_full;
    logic fill_zero;
    logic key_match;
    logic idx_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/cht_ctrl.sv =====
// Controller state machine of the chained hash table.
`default_nettype none

module cht_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cht_pkg::dp_status_t dp_st,
  output cht_pkg::ctrl_cmd_t      cmd
);
  import cht_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (dp_st.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (dp_st.mod_done) begin
          state_next = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        state_next = S_FILL_CHK;
      end
      S_FILL_CHK: begin
        if (dp_st.is_search && !dp_st.fill_zero) begin
          state_next = S_KEY_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_KEY_RD: begin
        state_next = S_KEY_CMP;
      end
      S_KEY_CMP: begin
        if (dp_st.key_match || dp_st.idx_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_KEY_RD;
        end
      end
      S_DONE: begin
        if (!dp_st.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
      end
      S_FILL_RD: begin
        cmd.fill_rd = 1'b1;
      end
      S_FILL_CHK: begin
        cmd.idx_clr = 1'b1;
        if (!dp_st.is_search) begin
          cmd.res_load = 1'b1;
          if (dp_st.fill_full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.ins_wr     = 1'b1;
            cmd.res_status = ST_INSERTED;
          end
        end else if (dp_st.fill_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISSING;
        end
      end
      S_KEY_RD: begin
        cmd.key_rd = 1'b1;
      end
      S_KEY_CMP: begin
        if (dp_st.key_match) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FOUND;
        end else if (dp_st.idx_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISSING;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        cmd.out_load = !dp_st.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/cht_datapath.sv =====
// Datapath of the chained hash table: bucket remainder, key and fill memories, result registers.
`default_nettype none

module cht_datapath #(
  parameter int BUCKETS = 3,
  parameter int DEPTH   = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cht_pkg::ctrl_cmd_t          cmd,
  output cht_pkg::dp_status_t              dp_st,
  input  wire logic                        in_cmd,
  input  wire logic [cht_pkg::KEY_W-1:0]   in_key,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [cht_pkg::POS_W-1:0]        out_pos
);
  import cht_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRIES = BUCKETS * DEPTH;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = KEY_W + 32;
  localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / 64'(BUCKETS));

  logic             op;
  logic [KEY_W-1:0] key;
  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] q_est;
  logic [BW:0]      rem_wide;
  logic [CNT_W-1:0] mod_cnt;
  logic [BW-1:0]    rem;
  logic [BW-1:0]    clr_idx;
  logic [FW-1:0]    fill_q;
  logic [AW-1:0]    base;
  logic [IW-1:0]    idx;
  logic [FW-1:0]    idx_p1;
  logic [FW-1:0]    fill_p1;
  logic [AW-1:0]    key_addr;
  logic [KEY_W-1:0] rd_key;
  status_t          res_status;
  logic [POS_W-1:0] res_pos;

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [FW-1:0]    fill_mem [BUCKETS];

  // The reciprocal quotient is never high and at most one low, so the remainder
  // is below twice the bucket count and one compare and subtract finishes it.
  assign prod = PW'(key) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op      <= in_cmd;
      key     <= in_key;
      mod_cnt <= CNT_W'(MOD_STAGES - 1);
    end else if (cmd.mod_step) begin
      mod_cnt  <= mod_cnt - CNT_W'(1);
      q_est    <= prod[PW-1:32];
      rem_wide <= key[BW:0] - (BW + 1)'(q_est[BW:0] * (BW + 1)'(BUCKETS));
      if (rem_wide >= (BW + 1)'(BUCKETS)) begin
        rem <= BW'(rem_wide - (BW + 1)'(BUCKETS));
      end else begin
        rem <= rem_wide[BW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_wr && (clr_idx != BW'(BUCKETS - 1))) begin
      clr_idx <= clr_idx + BW'(1);
    end
  end

  assign fill_p1 = fill_q + FW'(1);
  assign idx_p1  = FW'(idx) + FW'(1);

  // Fill count memory: cleared by a sweep after reset, then one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      fill_mem[clr_idx] <= '0;
    end else if (cmd.ins_wr) begin
      fill_mem[rem] <= fill_p1;
    end
    if (cmd.fill_rd) begin
      fill_q <= fill_mem[rem];
      base   <= AW'(32'(rem) * DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  assign key_addr = cmd.ins_wr ? AW'(base + AW'(fill_q)) : AW'(base + AW'(idx));

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      key_mem[key_addr] <= key;
    end
    if (cmd.key_rd) begin
      rd_key <= key_mem[key_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      case (cmd.res_status)
        ST_INSERTED: res_pos <= POS_W'(fill_p1);
        ST_FOUND:    res_pos <= POS_W'(idx_p1);
        default:     res_pos <= '0;
      endcase
    end
  end

  // Output register: holds a finished result while the next transfer is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_pos    <= res_pos;
    end
  end

  assign dp_st.clr_done  = (clr_idx == BW'(BUCKETS - 1));
  assign dp_st.mod_done  = (mod_cnt == '0);
  assign dp_st.is_search = (op == CMD_SEARCH);
  assign dp_st.fill_full = (fill_q == FW'(DEPTH));
  assign dp_st.fill_zero = (fill_q == '0);
  assign dp_st.key_match = (rd_key == key);
  assign dp_st.idx_last  = (idx_p1 == fill_q);
  assign dp_st.out_busy  = out_valid && !out_ready;

endmodule

`default_nettype wire

// ===== src/chained_hash_table.sv =====
// Top level of the chained hash table.
`default_nettype none

// Hash table with separate chaining over BUCKETS chains of at most DEPTH keys each.
// A transfer on the slave side is an insert (s_tuser 0) or a search (s_tuser 1) of the key
// in s_tdata; the bucket is the key modulo BUCKETS. Each transfer yields one result on the
// master side: status in m_tuser and the 1-based chain position in m_tdata. After acceptance
// the key passes through the bucket remainder, a fill count read and a fill check; an insert
// then writes its key unless the chain is full, and a search reads and compares chain entries
// in turn until a match or the end of the chain. The bucket remainder is built by a reciprocal
// multiply, a subtract and one correction, and the key memory serves one read per compare. The
// next transfer is accepted in the cycle after a result enters the output register; a result
// still waiting in the output register holds the finished item back. One item is in work at a
// time, while an earlier result may still wait in the output register. After reset, a clearing
// pass over the buckets zeroes the fill counts before the first transfer is accepted.
module chained_hash_table #(
  parameter int BUCKETS = 3,
  parameter int DEPTH   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [30:0] key, [31] zero
  input  wire logic        s_tuser,  // [0] cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // [3:0] position, [7:4] zero
  output logic [1:0]       m_tuser   // [1:0] status
);
  import cht_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       dp_st;
  logic [POS_W-1:0] pos;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .dp_st    (dp_st),
    .cmd      (cmd)
  );

  cht_datapath #(
    .BUCKETS (BUCKETS),
    .DEPTH   (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .dp_st      (dp_st),
    .in_cmd     (s_tuser),
    .in_key     (s_tdata[KEY_W-1:0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_pos    (pos)
  );

  assign m_tdata = {4'b0000, pos};

endmodule

`default_nettype wire
